FILE: hw/rtl/bc1_pkg.sv
package bc1_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PIXELS      = 16;
    localparam int PIX_W       = $clog2(PIXELS);

    localparam logic [19:0] DIV3_MUL  = 20'd683;
    localparam logic [7:0]  ALPHA_ON  = 8'd255;
    localparam logic [7:0]  ALPHA_OFF = 8'd0;

    typedef struct packed {
        logic [15:0] endpoint_a;
        logic [15:0] endpoint_b;
        logic [31:0] index_word;
    } in_item_t;

    typedef struct packed {
        logic [3:0] pixel_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } color_t;

    typedef struct packed {
        color_t [3:0] palette;
        logic [31:0]  index_word;
    } block_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // floor(x / 3) for x below 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * DIV3_MUL;
        return prod[18:11];
    endfunction

endpackage

FILE: hw/rtl/bc1_color_block_decoder.sv
// BC1 color block decoder: each pushed transaction is one 64-bit block; the
// front end expands the endpoints and builds the four-entry palette in the
// same cycle and stores it in a two-block queue, and the back end sequencer
// reads out one pixel per cycle from its output register while that register
// is empty or being popped, 16 pixels per block, with no gap between blocks.
// A block that finds the back end idle passes through the queue, the block
// register and the output register before its first pixel appears. dxt1_mode
// resets to 1 and should only be written while no block is in flight.
module bc1_color_block_decoder
    import bc1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    logic          dxt1_mode_reg;
    block_t        front_blk;
    block_t        q_data;
    logic          q_pop;
    logic          accept;
    queue_status_t q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dxt1_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            dxt1_mode_reg <= cfg_data;
        end
    end

    bc1_front u_front (
        .in_item   (in_item),
        .dxt1_mode (dxt1_mode_reg),
        .blk       (front_blk)
    );

    bc1_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_blk),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    bc1_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_valid  (!q_status.empty),
        .q_pop    (q_pop),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

FILE: hw/rtl/bc1_front.sv
module bc1_front
    import bc1_pkg::*;
(
    input  in_item_t in_item,
    input  logic     dxt1_mode,
    output block_t   blk
);

    color_t     c0;
    color_t     c1;
    color_t     c2;
    color_t     c3;
    logic       three;
    logic [8:0] sum_r;
    logic [8:0] sum_g;
    logic [8:0] sum_b;

    always_comb
    begin
        three = dxt1_mode && (in_item.endpoint_a <= in_item.endpoint_b);

        c0.r = expand5(in_item.endpoint_a[15:11]);
        c0.g = expand6(in_item.endpoint_a[10:5]);
        c0.b = expand5(in_item.endpoint_a[4:0]);
        c0.a = ALPHA_ON;
        c1.r = expand5(in_item.endpoint_b[15:11]);
        c1.g = expand6(in_item.endpoint_b[10:5]);
        c1.b = expand5(in_item.endpoint_b[4:0]);
        c1.a = ALPHA_ON;

        sum_r = 9'(c0.r) + 9'(c1.r);
        sum_g = 9'(c0.g) + 9'(c1.g);
        sum_b = 9'(c0.b) + 9'(c1.b);

        if (three)
        begin
            c2.r = sum_r[8:1];
            c2.g = sum_g[8:1];
            c2.b = sum_b[8:1];
            c2.a = ALPHA_ON;
            c3   = '0;
            c3.a = ALPHA_OFF;
        end
        else
        begin
            c2.r = div3(10'(sum_r) + 10'(c0.r));
            c2.g = div3(10'(sum_g) + 10'(c0.g));
            c2.b = div3(10'(sum_b) + 10'(c0.b));
            c2.a = ALPHA_ON;
            c3.r = div3(10'(sum_r) + 10'(c1.r));
            c3.g = div3(10'(sum_g) + 10'(c1.g));
            c3.b = div3(10'(sum_b) + 10'(c1.b));
            c3.a = ALPHA_ON;
        end

        blk.palette[0] = c0;
        blk.palette[1] = c1;
        blk.palette[2] = c2;
        blk.palette[3] = c3;
        blk.index_word = in_item.index_word;
    end

endmodule

FILE: hw/rtl/bc1_queue.sv
module bc1_queue
    import bc1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  block_t        wr_data,
    input  logic          rd_en,
    output block_t        rd_data,
    output queue_status_t status
);

    block_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/bc1_back.sv
module bc1_back
    import bc1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  block_t    q_data,
    input  logic      q_valid,
    output logic      q_pop,
    output out_item_t out_item,
    output logic      empty,
    input  logic      pop
);

    block_t            blk_reg;
    logic              active_reg;
    logic              active_next;
    logic [PIX_W-1:0]  cnt_reg;
    logic [PIX_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;
    logic              adv;
    logic              emit;
    logic              at_last;
    logic [1:0]        sel;
    color_t            pix;

    assign adv      = !out_valid_reg || pop;
    assign emit     = active_reg && adv;
    assign at_last  = (cnt_reg == PIX_W'(PIXELS - 1));
    assign q_pop    = q_valid && (!active_reg || (emit && at_last));
    assign out_item = out_item_reg;
    assign empty    = !out_valid_reg;

    always_comb
    begin
        sel  = 2'(blk_reg.index_word >> {cnt_reg, 1'b0});
        pix  = blk_reg.palette[sel];

        out_item_next.pixel_number = 4'(cnt_reg);
        out_item_next.red          = pix.r;
        out_item_next.green        = pix.g;
        out_item_next.blue         = pix.b;
        out_item_next.alpha        = pix.a;
        out_item_next.last         = at_last;

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        cnt_next = emit ? cnt_reg + 1'b1 : cnt_reg;

        active_next = active_reg;
        if (q_pop)
        begin
            active_next = 1'b1;
        end
        else if (emit && at_last)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            blk_reg <= q_data;
        end
        if (emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

FILE: hw/rtl/bc1_checker.sv
module bc1_checker
    import bc1_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    // last marks only the final pixel
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.last) |-> (out_item.pixel_number == 4'd15))
        else $error("last on wrong pixel");

    // within a block the next pixel follows right after a pop
    a_pixel_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !out_item.last) |=>
        (!empty && out_item.pixel_number == $past(out_item.pixel_number) + 4'd1))
        else $error("pixel sequence broken");

    a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.alpha == 8'd255 || out_item.alpha == 8'd0))
        else $error("bad alpha");

    // transparent entry is black
    a_transparent_black: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.alpha == 8'd0) |->
        (out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0))
        else $error("transparent pixel not black");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("stalled transaction changed");

endmodule

bind bc1_color_block_decoder bc1_checker u_bc1_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
